// ===== hw/rtl/hrpfa_pkg.sv =====
`default_nettype none

package hrpfa_pkg;

   // Pool geometry and field widths.
   localparam int POOL_DEPTH = 64;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int FILL_W     = IDX_W + 1;
   localparam int ADDR_W     = IDX_W + 1;
   localparam int FRAME_W    = 32;
   localparam int KEY_W      = 64;
   localparam int WORD_W     = 64;
   localparam int ENTRY_W    = 6;
   localparam int FIF_W      = 5;

   // Descriptor words hashed per pool kind.
   localparam int TEX_WORDS  = 7;
   localparam int BUF_WORDS  = 4;
   localparam int WCNT_W     = $clog2(TEX_WORDS);

   localparam logic [KEY_W-1:0] MIX_CONST = 64'h9e3779b97f4a7c15;
   localparam int MIX_SHL = 6;
   localparam int MIX_SHR = 2;

   localparam logic [FIF_W-1:0] FIF_RESET = 5'd2;

   // Request opcodes and pool kinds.
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;
   localparam logic POOL_TEX   = 1'b0;
   localparam logic POOL_BUF   = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [KEY_W-1:0]  key_type;

   // One step of the golden-ratio hash combine.
   function automatic key_type mix_word(input key_type h, input word_type w);
      mix_word = h ^ (w + MIX_CONST + (h << MIX_SHL) + (h >> MIX_SHR));
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrpfa_if.sv =====
`default_nettype none

interface hrpfa_req_if;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic                     pool_kind;
   hrpfa_pkg::word_type      desc_word_0;
   hrpfa_pkg::word_type      desc_word_1;
   hrpfa_pkg::word_type      desc_word_2;
   hrpfa_pkg::word_type      desc_word_3;
   hrpfa_pkg::word_type      desc_word_4;
   hrpfa_pkg::word_type      desc_word_5;
   hrpfa_pkg::word_type      desc_word_6;

   modport source (output valid, op, pool_kind, desc_word_0, desc_word_1, desc_word_2,
                   desc_word_3, desc_word_4, desc_word_5, desc_word_6, input ready);
   modport sink   (input valid, op, pool_kind, desc_word_0, desc_word_1, desc_word_2,
                   desc_word_3, desc_word_4, desc_word_5, desc_word_6, output ready);
endinterface

interface hrpfa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hrpfa_pkg::ENTRY_W-1:0]     entry_index;
   logic                              created;
   logic                              pool_full;

   modport source (output valid, entry_index, created, pool_full, input ready);
   modport sink   (input valid, entry_index, created, pool_full, output ready);
endinterface

interface hrpfa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hrpfa_pkg::FIF_W-1:0]       wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hashed_resource_pool_frame_aging_top.sv =====
// Channel   Role   Payload
// csr_ch    sink   wdata: frames_in_flight (5 bits)
// req_ch    sink   op, pool_kind, desc_word_0 .. desc_word_6
// rsp_ch    source entry_index, created, pool_full
//
// Acquire: hashes each descriptor word in turn (7 texture, 4 buffer), then scans the
// filled entries of the pool through the registered key memory read, then posts the
// response. Release: sweeps all 2*POOL_DEPTH entries of both pools through the stamp
// memory port, then posts the response. Reset is synchronous and needs no clearing
// pass. One request is in work at a time; req_ch is ready whenever no request is in
// work, even while a response waits in the output register for rsp_ch.ready.
`default_nettype none

module hashed_resource_pool_frame_aging_top (
   input  wire           clock,
   input  wire           reset,
   hrpfa_csr_if.sink     csr_ch,
   hrpfa_req_if.sink     req_ch,
   hrpfa_rsp_if.source   rsp_ch
);

   localparam int NENT = 2 * hrpfa_pkg::POOL_DEPTH;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_HASH    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_RELEASE = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic                                pool_ff, pool_in;
   hrpfa_pkg::word_type                 words_ff [hrpfa_pkg::TEX_WORDS];
   hrpfa_pkg::word_type                 words_in [hrpfa_pkg::TEX_WORDS];
   logic [hrpfa_pkg::WCNT_W-1:0]        word_cnt_ff, word_cnt_in;
   hrpfa_pkg::key_type                  key_ff, key_in;
   logic [hrpfa_pkg::FILL_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                                cmp_vld_ff, cmp_vld_in;
   logic [hrpfa_pkg::IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [hrpfa_pkg::ADDR_W-1:0]        sweep_ff, sweep_in;
   logic [hrpfa_pkg::FILL_W-1:0]        fill_ff [2];
   logic [hrpfa_pkg::FILL_W-1:0]        fill_in [2];
   logic [hrpfa_pkg::FRAME_W-1:0]       frame_ff, frame_in;
   logic [hrpfa_pkg::FIF_W-1:0]         fif_ff, fif_in;
   logic [NENT-1:0]                     busy_ff, busy_in;
   logic [NENT-1:0]                     freed_ff, freed_in;
   logic [hrpfa_pkg::ENTRY_W-1:0]       res_idx_ff, res_idx_in;
   logic                                res_created_ff, res_created_in;
   logic                                res_full_ff, res_full_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hrpfa_pkg::ENTRY_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic                                rsp_created_ff, rsp_created_in;
   logic                                rsp_full_ff, rsp_full_in;

   // Key and stamp memories, one read port and one write port each.
   hrpfa_pkg::key_type                  key_mem   [NENT];
   logic [hrpfa_pkg::FRAME_W-1:0]       stamp_mem [NENT];
   hrpfa_pkg::key_type                  key_rd_ff;
   logic [hrpfa_pkg::FRAME_W-1:0]       stamp_rd_ff;
   logic [hrpfa_pkg::ADDR_W-1:0]        rd_addr;
   logic [hrpfa_pkg::ADDR_W-1:0]        key_waddr;
   logic                                key_we;
   logic                                stamp_we;

   logic                                req_fire;
   logic                                issue;
   logic [hrpfa_pkg::FILL_W-1:0]        fill_sel;
   logic [hrpfa_pkg::ADDR_W-1:0]        cmp_addr;
   logic [hrpfa_pkg::FRAME_W-1:0]       age;
   logic                                hit;
   logic [hrpfa_pkg::WCNT_W-1:0]        last_word;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.entry_index = rsp_idx_ff;
   assign rsp_ch.created     = rsp_created_ff;
   assign rsp_ch.pool_full   = rsp_full_ff;

   assign fill_sel  = fill_ff[pool_ff];
   assign issue     = (state_ff == S_SCAN) && (scan_cnt_ff < fill_sel);
   assign rd_addr   = {pool_ff, scan_cnt_ff[hrpfa_pkg::IDX_W-1:0]};
   assign cmp_addr  = {pool_ff, cmp_idx_ff};
   assign key_waddr = {pool_ff, fill_sel[hrpfa_pkg::IDX_W-1:0]};
   assign last_word = (pool_ff == hrpfa_pkg::POOL_BUF) ?
                      hrpfa_pkg::WCNT_W'(hrpfa_pkg::BUF_WORDS - 1) :
                      hrpfa_pkg::WCNT_W'(hrpfa_pkg::TEX_WORDS - 1);

   // Age wraps with the frame counter, so a plain subtraction is enough.
   assign age = frame_ff - stamp_rd_ff;
   assign hit = !busy_ff[cmp_addr] && (key_rd_ff == key_ff) &&
                (!freed_ff[cmp_addr] || (age >= hrpfa_pkg::FRAME_W'(fif_ff)));

   always_comb begin
      state_in       = state_ff;
      pool_in        = pool_ff;
      words_in       = words_ff;
      word_cnt_in    = word_cnt_ff;
      key_in         = key_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = scan_cnt_ff[hrpfa_pkg::IDX_W-1:0];
      sweep_in       = sweep_ff;
      fill_in        = fill_ff;
      frame_in       = frame_ff;
      fif_in         = fif_ff;
      busy_in        = busy_ff;
      freed_in       = freed_ff;
      res_idx_in     = res_idx_ff;
      res_created_in = res_created_ff;
      res_full_in    = res_full_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in     = rsp_idx_ff;
      rsp_created_in = rsp_created_ff;
      rsp_full_in    = rsp_full_ff;
      key_we         = 1'b0;
      stamp_we       = 1'b0;

      if (csr_ch.valid) begin
         fif_in = csr_ch.wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pool_in     = req_ch.pool_kind;
               words_in[0] = req_ch.desc_word_0;
               words_in[1] = req_ch.desc_word_1;
               words_in[2] = req_ch.desc_word_2;
               words_in[3] = req_ch.desc_word_3;
               words_in[4] = req_ch.desc_word_4;
               words_in[5] = req_ch.desc_word_5;
               words_in[6] = req_ch.desc_word_6;
               word_cnt_in = '0;
               key_in      = '0;
               sweep_in    = '0;
               state_in    = (req_ch.op == hrpfa_pkg::OP_RELEASE) ? S_RELEASE : S_HASH;
            end
         end
         S_HASH: begin
            key_in      = hrpfa_pkg::mix_word(key_ff, words_ff[word_cnt_ff]);
            word_cnt_in = word_cnt_ff + 1'b1;
            if (word_cnt_ff == last_word) begin
               scan_cnt_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // Reads run one entry ahead of the compare on the registered data.
            cmp_vld_in  = issue;
            scan_cnt_in = scan_cnt_ff + hrpfa_pkg::FILL_W'(issue);
            if (cmp_vld_ff && hit) begin
               busy_in[cmp_addr] = 1'b1;
               res_idx_in        = hrpfa_pkg::ENTRY_W'(cmp_idx_ff);
               res_created_in    = 1'b0;
               res_full_in       = 1'b0;
               cmp_vld_in        = 1'b0;
               state_in          = S_DONE;
            end else if (!cmp_vld_ff && !issue) begin
               if (fill_sel == hrpfa_pkg::FILL_W'(hrpfa_pkg::POOL_DEPTH)) begin
                  res_idx_in     = '0;
                  res_created_in = 1'b0;
                  res_full_in    = 1'b1;
               end else begin
                  key_we             = 1'b1;
                  busy_in[key_waddr]  = 1'b1;
                  freed_in[key_waddr] = 1'b0;
                  fill_in[pool_ff]    = fill_sel + 1'b1;
                  res_idx_in          = hrpfa_pkg::ENTRY_W'(fill_sel[hrpfa_pkg::IDX_W-1:0]);
                  res_created_in      = 1'b1;
                  res_full_in         = 1'b0;
               end
               state_in = S_DONE;
            end
         end
         S_RELEASE: begin
            if (busy_ff[sweep_ff]) begin
               stamp_we           = 1'b1;
               busy_in[sweep_ff]  = 1'b0;
               freed_in[sweep_ff] = 1'b1;
            end
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == hrpfa_pkg::ADDR_W'(NENT - 1)) begin
               frame_in       = frame_ff + 1'b1;
               res_idx_in     = '0;
               res_created_in = 1'b0;
               res_full_in    = 1'b0;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_idx_in     = res_idx_ff;
               rsp_created_in = res_created_ff;
               rsp_full_in    = res_full_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_cnt_ff  <= '0;
         scan_cnt_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         sweep_ff     <= '0;
         fill_ff[0]   <= '0;
         fill_ff[1]   <= '0;
         frame_ff     <= '0;
         fif_ff       <= hrpfa_pkg::FIF_RESET;
         busy_ff      <= '0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_cnt_ff  <= word_cnt_in;
         scan_cnt_ff  <= scan_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         frame_ff     <= frame_in;
         fif_ff       <= fif_in;
         busy_ff      <= busy_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pool_ff        <= pool_in;
      words_ff       <= words_in;
      key_ff         <= key_in;
      cmp_idx_ff     <= cmp_idx_in;
      res_idx_ff     <= res_idx_in;
      res_created_ff <= res_created_in;
      res_full_ff    <= res_full_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[sweep_ff] <= frame_ff;
      end
      stamp_rd_ff <= stamp_mem[rd_addr];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= hrpfa_pkg::FILL_W'(hrpfa_pkg::POOL_DEPTH)) &&
      (fill_ff[1] <= hrpfa_pkg::FILL_W'(hrpfa_pkg::POOL_DEPTH)))
      else $error("pool fill count beyond pool depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_created_ff && rsp_full_ff))
      else $error("response flagged both created and pool full");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_HASH || state_ff == S_RELEASE))
      else $error("accepted request did not start work");

   a_frame_only_on_release: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(frame_ff)) |-> $past(state_ff == S_RELEASE))
      else $error("frame counter moved outside a release sweep");

endmodule

`default_nettype wire
